FILE: src/pdtw_pkg.sv
package pdtw_pkg;

    // tree and store geometry
    localparam int LEVEL_COUNT     = 7;
    localparam int PIXEL_ADDR_BITS = 16;
    localparam int NODE_COUNT      = (1 << LEVEL_COUNT) - 1;
    localparam int BOTTOM_FIRST    = (NODE_COUNT - 1) / 2;
    localparam int NODE_W          = LEVEL_COUNT;
    localparam int STEP_W          = $clog2(LEVEL_COUNT);
    localparam int PIXEL_DEPTH     = 1 << PIXEL_ADDR_BITS;

    // request and result field widths
    localparam int OPCODE_W   = 2;
    localparam int ADDRESS_W  = 16;
    localparam int DATA_W     = 9;
    localparam int OFFSET_W   = 16;
    localparam int LINK_W     = 7;
    localparam int LANDMARK_W = 18;
    localparam int LEAF_W     = 6;
    localparam int PIXEL_W    = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SIZE_W     = 9;
    localparam int COEF_W     = 24;
    localparam int COORD_W    = 8;
    localparam int FRAC_BITS  = 22;
    localparam int LAND_SHIFT = 14;

    // datapath widths
    localparam int PROD_W      = COEF_W + OFFSET_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int INT_W       = ACC_W - 1 - FRAC_BITS;
    localparam int LIN_W       = COORD_W + SIZE_W;
    localparam int PIX_CMP_W   = (PIXEL_ADDR_BITS + 1 > LIN_W) ? PIXEL_ADDR_BITS + 1 : LIN_W;
    localparam int LINK_CMP_W  = (LINK_W > NODE_W) ? LINK_W : NODE_W;
    localparam int DIFF_W      = PIXEL_W + 2;

    localparam logic [PIX_CMP_W-1:0]  PIXEL_LIMIT = PIX_CMP_W'(1) << PIXEL_ADDR_BITS;
    localparam logic [SIZE_W-1:0]     SIZE_MAX    = SIZE_W'(256);

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_NODE  = 2'd0,
        OP_WRITE_PIXEL = 2'd1,
        OP_QUERY       = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_COLS = 3'd0,
        CFG_IMAGE_ROWS = 3'd1,
        CFG_COEF_XX    = 3'd2,
        CFG_COEF_XY    = 3'd3,
        CFG_COEF_YX    = 3'd4,
        CFG_COEF_YY    = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SUM,
        ST_COORD,
        ST_ADDR,
        ST_DECIDE,
        ST_LEAF,
        ST_DONE
    } state_t;

    // one entry of the node memory
    typedef struct packed {
        logic signed [DATA_W-1:0]   threshold;
        logic signed [OFFSET_W-1:0] offset_a_x;
        logic signed [OFFSET_W-1:0] offset_a_y;
        logic signed [OFFSET_W-1:0] offset_b_x;
        logic signed [OFFSET_W-1:0] offset_b_y;
        logic [LINK_W-1:0]          left_index;
        logic [LINK_W-1:0]          right_index;
        logic                       is_leaf;
    } node_word_t;

    localparam int NODE_WORD_W = $bits(node_word_t);

    // zero acts as one, above the maximum acts as the maximum
    function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_MAX)
            r = SIZE_MAX;
        else
            r = v;
        return r;
    endfunction

    // fixed point position to pixel coordinate, truncated and clamped
    function automatic logic [COORD_W-1:0] to_coord(
        input logic signed [ACC_W-1:0] acc,
        input logic [SIZE_W-1:0]       lim
    );
        logic [SIZE_W-1:0]  lim_m1;
        logic [INT_W-1:0]   ipart;
        logic [COORD_W-1:0] r;
        lim_m1 = lim - SIZE_W'(1);
        ipart  = acc[ACC_W-2:FRAC_BITS];
        if (acc[ACC_W-1])
            r = '0;
        else if (ipart > INT_W'(lim_m1))
            r = lim_m1[COORD_W-1:0];
        else
            r = ipart[COORD_W-1:0];
        return r;
    endfunction

endpackage

FILE: src/pdtw_cmd_if.sv
interface pdtw_cmd_if
    import pdtw_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic [OPCODE_W-1:0]          opcode;
    logic [ADDRESS_W-1:0]         address;
    logic signed [DATA_W-1:0]     data_value;
    logic signed [OFFSET_W-1:0]   offset_a_x;
    logic signed [OFFSET_W-1:0]   offset_a_y;
    logic signed [OFFSET_W-1:0]   offset_b_x;
    logic signed [OFFSET_W-1:0]   offset_b_y;
    logic [LINK_W-1:0]            left_index;
    logic [LINK_W-1:0]            right_index;
    logic                         is_leaf;
    logic signed [LANDMARK_W-1:0] landmark_x;
    logic signed [LANDMARK_W-1:0] landmark_y;

    modport source (
        output valid, opcode, address, data_value, offset_a_x, offset_a_y,
               offset_b_x, offset_b_y, left_index, right_index, is_leaf,
               landmark_x, landmark_y,
        input  ready
    );

    modport sink (
        input  valid, opcode, address, data_value, offset_a_x, offset_a_y,
               offset_b_x, offset_b_y, left_index, right_index, is_leaf,
               landmark_x, landmark_y,
        output ready
    );
endinterface

FILE: src/pdtw_rsp_if.sv
interface pdtw_rsp_if
    import pdtw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [LEAF_W-1:0] leaf_index;
    logic              fault;

    modport source (
        output valid, leaf_index, fault,
        input  ready
    );

    modport sink (
        input  valid, leaf_index, fault,
        output ready
    );
endinterface

FILE: src/pixel_difference_tree_walk.sv
// channel  role    payload
// -------  ------  ---------------------------------------------------------
// cmd      sink    opcode, address, data_value, four offsets, links, is_leaf,
//                  landmark_x, landmark_y
// rsp      source  leaf_index, fault
// cfg      write   cfg_we, cfg_index, cfg_data (no read-back)
//
// Writes go to memory as they are accepted. A query evaluates n nodes (at most
// LEVEL_COUNT-1), each with both sample points in turn through MUL_X, MUL_Y, SUM,
// COORD and ADDR on the two shared 24x16 multipliers and the single pixel memory
// read port, then DECIDE and LEAF (no LEAF when the last node points outside the
// table). The result loads from DONE; the next request is taken the cycle after.
// Reset (rst_n, async low) clears control and configuration, not the memories.
// A finished result sits in an output register; further requests are taken while
// it waits, and a later query holds in its last state until the register frees.
module pixel_difference_tree_walk
    import pdtw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pdtw_cmd_if.sink              cmd,
    pdtw_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    state_t state_reg, state_next;

    // configuration
    logic [SIZE_W-1:0]        cols_reg, rows_reg;
    logic signed [COEF_W-1:0] coef_xx_reg, coef_xy_reg, coef_yx_reg, coef_yy_reg;
    logic [SIZE_W-1:0]        cols_fit, rows_fit;

    // walk state
    logic [NODE_W-1:0]            node_reg;
    logic [STEP_W-1:0]            step_reg;
    logic                         point_reg;
    logic signed [LANDMARK_W-1:0] land_x_reg, land_y_reg;
    logic signed [PROD_W-1:0]     prod_x_reg, prod_y_reg;
    logic signed [ACC_W-1:0]      acc_x_reg, acc_y_reg;
    logic [COORD_W-1:0]           x_reg, y_reg;
    logic                         oob_reg;
    logic [PIXEL_W-1:0]           pix_a_reg;
    logic [LEAF_W-1:0]            res_leaf_reg;
    logic                         res_fault_reg;

    // result register
    logic              rsp_valid_reg;
    logic [LEAF_W-1:0] rsp_leaf_reg;
    logic              rsp_fault_reg;

    // memory ports
    logic                        node_we, node_re;
    logic [NODE_W-1:0]           node_rd_addr;
    logic [NODE_WORD_W-1:0]      node_rdata;
    node_word_t                  node_wdata, node_word;
    logic                        pix_we, pix_re;
    logic [PIXEL_ADDR_BITS-1:0]  pix_rd_addr;
    logic [PIXEL_W-1:0]          pix_rdata;

    // combinational datapath
    logic                         cmd_fire, out_free;
    logic signed [OFFSET_W-1:0]   off_x, off_y, mul_off;
    logic signed [COEF_W-1:0]     mul_cx, mul_cy;
    logic signed [PROD_W-1:0]     mul_x, mul_y;
    logic signed [ACC_W-1:0]      land_x_ext, land_y_ext;
    logic [LIN_W-1:0]             pix_lin;
    logic                         pix_oob;
    logic [PIXEL_W-1:0]           pix_b;
    logic signed [DIFF_W-1:0]     diff, thr_ext;
    logic                         go_left, link_ok, node_bottom;
    logic [LINK_W-1:0]            next_link;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign cols_fit  = fit_size(cols_reg);
    assign rows_fit  = fit_size(rows_reg);
    assign node_word = node_word_t'(node_rdata);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg    <= SIZE_MAX;
            rows_reg    <= SIZE_MAX;
            coef_xx_reg <= '0;
            coef_xy_reg <= '0;
            coef_yx_reg <= '0;
            coef_yy_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_IMAGE_COLS: cols_reg    <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_ROWS: rows_reg    <= cfg_data[SIZE_W-1:0];
                CFG_COEF_XX:    coef_xx_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_XY:    coef_xy_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_YX:    coef_yx_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_YY:    coef_yy_reg <= cfg_data[COEF_W-1:0];
                default:        ;
            endcase
        end
    end

    // node memory write from request
    assign node_wdata.threshold   = cmd.data_value;
    assign node_wdata.offset_a_x  = cmd.offset_a_x;
    assign node_wdata.offset_a_y  = cmd.offset_a_y;
    assign node_wdata.offset_b_x  = cmd.offset_b_x;
    assign node_wdata.offset_b_y  = cmd.offset_b_y;
    assign node_wdata.left_index  = cmd.left_index;
    assign node_wdata.right_index = cmd.right_index;
    assign node_wdata.is_leaf     = cmd.is_leaf;

    assign node_we = cmd_fire && (opcode_t'(cmd.opcode) == OP_WRITE_NODE)
                     && (cmd.address < ADDRESS_W'(NODE_COUNT));
    assign pix_we  = cmd_fire && (opcode_t'(cmd.opcode) == OP_WRITE_PIXEL)
                     && (PIX_CMP_W'(cmd.address) < PIXEL_LIMIT);

    pdtw_ram #(
        .WIDTH (NODE_WORD_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (node_we),
        .wr_addr (NODE_W'(cmd.address)),
        .wr_data (node_wdata),
        .rd_en   (node_re),
        .rd_addr (node_rd_addr),
        .rd_data (node_rdata)
    );

    pdtw_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (PIXEL_DEPTH)
    ) u_pixel_ram (
        .clk     (clk),
        .wr_en   (pix_we),
        .wr_addr (PIXEL_ADDR_BITS'(cmd.address)),
        .wr_data (cmd.data_value[PIXEL_W-1:0]),
        .rd_en   (pix_re),
        .rd_addr (pix_rd_addr),
        .rd_data (pix_rdata)
    );

    // shared multipliers: x offset in MUL_X, y offset in MUL_Y
    assign off_x   = point_reg ? node_word.offset_b_x : node_word.offset_a_x;
    assign off_y   = point_reg ? node_word.offset_b_y : node_word.offset_a_y;
    assign mul_off = (state_reg == ST_MUL_X) ? off_x : off_y;
    assign mul_cx  = (state_reg == ST_MUL_X) ? coef_xx_reg : coef_xy_reg;
    assign mul_cy  = (state_reg == ST_MUL_X) ? coef_yx_reg : coef_yy_reg;
    assign mul_x   = mul_cx * mul_off;
    assign mul_y   = mul_cy * mul_off;

    assign land_x_ext = ACC_W'(signed'({land_x_reg, LAND_SHIFT'(0)}));
    assign land_y_ext = ACC_W'(signed'({land_y_reg, LAND_SHIFT'(0)}));

    // linear pixel address and range check
    assign pix_lin     = LIN_W'(y_reg) * LIN_W'(cols_fit) + LIN_W'(x_reg);
    assign pix_oob     = PIX_CMP_W'(pix_lin) >= PIXEL_LIMIT;
    assign pix_rd_addr = PIXEL_ADDR_BITS'(pix_lin);
    assign pix_re      = (state_reg == ST_ADDR);

    // branch decision
    assign pix_b     = oob_reg ? '0 : pix_rdata;
    assign diff      = signed'(DIFF_W'(pix_a_reg)) - signed'(DIFF_W'(pix_b));
    assign thr_ext   = DIFF_W'(node_word.threshold);
    assign go_left   = diff < thr_ext;
    assign next_link = go_left ? node_word.left_index : node_word.right_index;
    assign link_ok   = LINK_CMP_W'(next_link) < LINK_CMP_W'(NODE_COUNT);
    assign node_bottom = node_reg >= NODE_W'(BOTTOM_FIRST);

    // node reads: root on a query, the chosen child on a decision
    always_comb
    begin
        node_re      = 1'b0;
        node_rd_addr = NODE_W'(next_link);
        if (state_reg == ST_IDLE)
        begin
            node_re      = cmd_fire && (opcode_t'(cmd.opcode) == OP_QUERY);
            node_rd_addr = '0;
        end
        else if (state_reg == ST_DECIDE)
        begin
            node_re = link_ok;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (opcode_t'(cmd.opcode) == OP_QUERY))
                    state_next = ST_MUL_X;
            end
            ST_MUL_X:  state_next = ST_MUL_Y;
            ST_MUL_Y:  state_next = ST_SUM;
            ST_SUM:    state_next = ST_COORD;
            ST_COORD:  state_next = ST_ADDR;
            ST_ADDR:   state_next = point_reg ? ST_DECIDE : ST_MUL_X;
            ST_DECIDE: state_next = link_ok ? ST_LEAF : ST_DONE;
            ST_LEAF:
            begin
                if (node_word.is_leaf || (step_reg == STEP_W'(LEVEL_COUNT - 1)))
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL_X;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // walk control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg  <= '0;
            step_reg  <= '0;
            point_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    node_reg  <= '0;
                    step_reg  <= '0;
                    point_reg <= 1'b0;
                end
                ST_ADDR:
                begin
                    point_reg <= 1'b1;
                end
                ST_DECIDE:
                begin
                    point_reg <= 1'b0;
                    if (link_ok)
                    begin
                        node_reg <= NODE_W'(next_link);
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_x_reg <= mul_x;
        prod_y_reg <= mul_y;
        case (state_reg)
            ST_IDLE:
            begin
                land_x_reg <= cmd.landmark_x;
                land_y_reg <= cmd.landmark_y;
            end
            ST_MUL_X:
            begin
                if (point_reg)
                    pix_a_reg <= oob_reg ? '0 : pix_rdata;
            end
            ST_MUL_Y:
            begin
                acc_x_reg <= land_x_ext + ACC_W'(prod_x_reg);
                acc_y_reg <= land_y_ext + ACC_W'(prod_y_reg);
            end
            ST_SUM:
            begin
                acc_x_reg <= acc_x_reg + ACC_W'(prod_x_reg);
                acc_y_reg <= acc_y_reg + ACC_W'(prod_y_reg);
            end
            ST_COORD:
            begin
                x_reg <= to_coord(acc_x_reg, cols_fit);
                y_reg <= to_coord(acc_y_reg, rows_fit);
            end
            ST_ADDR:
            begin
                oob_reg <= pix_oob;
            end
            ST_DECIDE:
            begin
                res_leaf_reg  <= '0;
                res_fault_reg <= 1'b1;
            end
            ST_LEAF:
            begin
                res_leaf_reg  <= '0;
                res_fault_reg <= 1'b1;
                if (node_word.is_leaf && node_bottom)
                begin
                    res_leaf_reg  <= LEAF_W'(node_reg - NODE_W'(BOTTOM_FIRST));
                    res_fault_reg <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_leaf_reg  <= '0;
            rsp_fault_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_leaf_reg  <= res_leaf_reg;
            rsp_fault_reg <= res_fault_reg;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.leaf_index = rsp_leaf_reg;
    assign rsp.fault      = rsp_fault_reg;

    // checks
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(LEVEL_COUNT - 1))
        else $error("tree step count beyond depth");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.fault) |-> (rsp.leaf_index == '0))
        else $error("faulted result carries a leaf index");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && rsp_valid_reg && !rsp.ready) |=> (state_reg == ST_DONE))
        else $error("result overwritten while output register busy");

    a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
        node_reg < NODE_W'(NODE_COUNT))
        else $error("walk node index out of range");

endmodule

FILE: src/pdtw_ram.sv
module pdtw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
